### hdl/sdinit_pkg.sv
// Types and constants shared by the SD card initialisation sequencer.
`timescale 1ns / 1ps

package sdinit_pkg;

    localparam logic [5:0]  CMD_GO_IDLE       = 6'd0;
    localparam logic [5:0]  CMD_ALL_SEND_CID  = 6'd2;
    localparam logic [5:0]  CMD_SEND_RCA      = 6'd3;
    localparam logic [5:0]  CMD_SEND_IF_COND  = 6'd8;
    localparam logic [5:0]  CMD_SEND_CSD      = 6'd9;
    localparam logic [5:0]  CMD_SD_SEND_OP    = 6'd41;
    localparam logic [5:0]  CMD_APP_CMD       = 6'd55;

    localparam logic [31:0] R1_ERR_MASK       = 32'hFDFF_E008;
    localparam logic [31:0] IF_COND_ARG       = 32'h0000_01AA;

    localparam logic [7:0]  ATTEMPT_LIMIT_RST = 8'd200;
    localparam logic [23:0] VOLT_WINDOW_RST   = 24'h10_0000;

    localparam logic        KIND_START        = 1'b0;
    localparam logic        KIND_RESPONSE     = 1'b1;

    localparam logic [1:0]  ST_OK             = 2'd0;
    localparam logic [1:0]  ST_TIMEOUT        = 2'd1;
    localparam logic [1:0]  ST_ERROR          = 2'd2;
    localparam logic [1:0]  ST_OTHER          = 2'd3;

    localparam logic [1:0]  OUTCOME_BUSY      = 2'd0;
    localparam logic [1:0]  OUTCOME_SUCCESS   = 2'd1;
    localparam logic [1:0]  OUTCOME_FAILURE   = 2'd2;

    localparam logic        CFG_ATTEMPT_LIMIT = 1'b0;
    localparam logic        CFG_VOLT_WINDOW   = 1'b1;

    typedef enum logic [3:0] {
        PH_IDLE = 4'd0,
        PH_C0   = 4'd1,
        PH_C8   = 4'd2,
        PH_C55  = 4'd3,
        PH_C41  = 4'd4,
        PH_C2   = 4'd5,
        PH_C3   = 4'd6,
        PH_C9   = 4'd7
    } phase_t;

    typedef struct packed {
        phase_t      phase;
        logic [7:0]  attempts_left;
        logic        host_hcs;
        logic [15:0] rel_addr;
        logic        card_hc;
    } seq_state_t;

    typedef struct packed {
        logic [7:0]  attempt_limit;
        logic [23:0] voltage_window;
    } cfg_t;

    typedef struct packed {
        logic        cmd_valid;
        logic [5:0]  cmd_index;
        logic [31:0] cmd_arg;
        logic        long_reply;
        logic        finished;
        logic [1:0]  outcome;
        logic [1:0]  fail_code;
        logic        high_capacity;
        logic [15:0] card_addr;
    } result_t;

endpackage

### hdl/sdinit_cfg.sv
// Configuration registers: attempt limit and OCR voltage window.
`timescale 1ns / 1ps

module sdinit_cfg (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  logic                cfg_index,
    input  logic [23:0]         cfg_data,
    output sdinit_pkg::cfg_t    cfg
);
    import sdinit_pkg::*;

    logic [7:0]  attempt_limit_reg;
    logic [23:0] voltage_window_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            attempt_limit_reg  <= ATTEMPT_LIMIT_RST;
            voltage_window_reg <= VOLT_WINDOW_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_ATTEMPT_LIMIT: attempt_limit_reg  <= cfg_data[7:0];
                CFG_VOLT_WINDOW:   voltage_window_reg <= cfg_data;
                default:           ;
            endcase
        end
    end

    assign cfg.attempt_limit  = attempt_limit_reg;
    assign cfg.voltage_window = voltage_window_reg;

endmodule

### hdl/sdinit_step.sv
// Next-state and command logic for one request of the initialisation sequence.
`timescale 1ns / 1ps

module sdinit_step (
    input  logic                    kind,
    input  logic [1:0]              reply_status,
    input  logic [31:0]             response_word,
    input  sdinit_pkg::seq_state_t  state_cur,
    input  sdinit_pkg::cfg_t        cfg,
    output sdinit_pkg::seq_state_t  state_next,
    output sdinit_pkg::result_t     result
);
    import sdinit_pkg::*;

    logic [31:0] app_arg;
    logic [31:0] op_arg;

    always_comb begin
        app_arg    = {state_cur.rel_addr, 16'h0000};
        op_arg     = {1'b0, state_cur.host_hcs, 6'b000000, cfg.voltage_window};
        state_next = state_cur;
        result     = '0;

        if (kind == KIND_START) begin
            state_next.host_hcs      = 1'b0;
            state_next.rel_addr      = 16'h0000;
            state_next.card_hc       = 1'b0;
            state_next.attempts_left = cfg.attempt_limit;
            state_next.phase         = PH_C0;
            result.cmd_valid         = 1'b1;
            result.cmd_index         = CMD_GO_IDLE;
        end else begin
            unique case (state_cur.phase)
                PH_C0: begin
                    if (reply_status != ST_OK) begin
                        result.finished  = 1'b1;
                        result.outcome   = OUTCOME_FAILURE;
                        result.fail_code = reply_status;
                        state_next.phase = PH_IDLE;
                    end else begin
                        result.cmd_valid = 1'b1;
                        result.cmd_index = CMD_SEND_IF_COND;
                        result.cmd_arg   = IF_COND_ARG;
                        state_next.phase = PH_C8;
                    end
                end
                PH_C8: begin
                    if (reply_status == ST_OK && response_word != IF_COND_ARG) begin
                        result.finished  = 1'b1;
                        result.outcome   = OUTCOME_FAILURE;
                        result.fail_code = ST_ERROR;
                        state_next.phase = PH_IDLE;
                    end else begin
                        // a card that does not answer CMD8 is an old one: no HCS request
                        if (reply_status == ST_OK) begin
                            state_next.host_hcs = 1'b1;
                        end
                        result.cmd_valid = 1'b1;
                        result.cmd_index = CMD_APP_CMD;
                        result.cmd_arg   = app_arg;
                        state_next.phase = PH_C55;
                    end
                end
                PH_C55: begin
                    if (reply_status != ST_OK) begin
                        result.finished  = 1'b1;
                        result.outcome   = OUTCOME_FAILURE;
                        result.fail_code = reply_status;
                        state_next.phase = PH_IDLE;
                    end else if ((response_word & R1_ERR_MASK) != 32'h0) begin
                        result.finished  = 1'b1;
                        result.outcome   = OUTCOME_FAILURE;
                        result.fail_code = ST_ERROR;
                        state_next.phase = PH_IDLE;
                    end else begin
                        result.cmd_valid = 1'b1;
                        result.cmd_index = CMD_SD_SEND_OP;
                        result.cmd_arg   = op_arg;
                        state_next.phase = PH_C41;
                    end
                end
                PH_C41: begin
                    if (reply_status == ST_TIMEOUT || reply_status == ST_ERROR) begin
                        result.finished  = 1'b1;
                        result.outcome   = OUTCOME_FAILURE;
                        result.fail_code = reply_status;
                        state_next.phase = PH_IDLE;
                    end else if (state_cur.attempts_left <= 8'd1) begin
                        // out of attempts, also when the card reports ready now
                        state_next.attempts_left = 8'd0;
                        result.finished  = 1'b1;
                        result.outcome   = OUTCOME_FAILURE;
                        result.fail_code = ST_ERROR;
                        state_next.phase = PH_IDLE;
                    end else begin
                        state_next.attempts_left = state_cur.attempts_left - 8'd1;
                        result.cmd_valid = 1'b1;
                        if (response_word[31]) begin
                            state_next.card_hc = response_word[30];
                            result.cmd_index   = CMD_ALL_SEND_CID;
                            result.long_reply  = 1'b1;
                            state_next.phase   = PH_C2;
                        end else begin
                            result.cmd_index = CMD_APP_CMD;
                            result.cmd_arg   = app_arg;
                            state_next.phase = PH_C55;
                        end
                    end
                end
                PH_C2: begin
                    if (reply_status != ST_OK) begin
                        result.finished  = 1'b1;
                        result.outcome   = OUTCOME_FAILURE;
                        result.fail_code = reply_status;
                        state_next.phase = PH_IDLE;
                    end else begin
                        result.cmd_valid = 1'b1;
                        result.cmd_index = CMD_SEND_RCA;
                        state_next.phase = PH_C3;
                    end
                end
                PH_C3: begin
                    if (reply_status != ST_OK) begin
                        result.finished  = 1'b1;
                        result.outcome   = OUTCOME_FAILURE;
                        result.fail_code = reply_status;
                        state_next.phase = PH_IDLE;
                    end else begin
                        state_next.rel_addr = response_word[31:16];
                        result.cmd_valid    = 1'b1;
                        result.cmd_index    = CMD_SEND_CSD;
                        result.cmd_arg      = {response_word[31:16], 16'h0000};
                        result.long_reply   = 1'b1;
                        state_next.phase    = PH_C9;
                    end
                end
                PH_C9: begin
                    result.finished  = 1'b1;
                    state_next.phase = PH_IDLE;
                    if (reply_status != ST_OK) begin
                        result.outcome   = OUTCOME_FAILURE;
                        result.fail_code = reply_status;
                    end else begin
                        result.outcome   = OUTCOME_SUCCESS;
                    end
                end
                default: begin
                    // drop responses that arrive while idle
                    state_next.phase = PH_IDLE;
                end
            endcase
        end

        result.high_capacity = state_next.card_hc;
        result.card_addr     = state_next.rel_addr;
    end

endmodule

### hdl/sd_card_init_sequencer_core.sv
// Top level of the host-side SD card initialisation sequencer.
`timescale 1ns / 1ps

// Host-side SD card power-up sequencer.
// Requests enter on the s_ channel (valid/ready): a start request (kind 0)
// issues CMD0 and restarts the sequence; each card response request (kind 1)
// yields the next command (CMD8, CMD55/ACMD41 loop, CMD2, CMD3, CMD9) or the
// final outcome. Every request gives exactly one result on the m_ channel.
// Configuration (attempt limit, voltage window) is written through the
// cfg_wr_en / cfg_index / cfg_data port; the user must write it only while no
// request is in flight, and the block itself does not enforce this. A request
// accepted on s_ is registered in the input register, then passes through the
// step logic into the result register, which presents it on m_.
// Throughput: one request per cycle while m_ready is high; the sequencer state
// updates in a single pass of the step logic between the input register and
// the result register. When the receiver stalls the result holds on m_, and
// one further request waits in the input register before s_ready drops.
// Reset (aresetn low, synchronous) returns the sequencer to idle, clears the
// card address and flags and loads the register defaults (200, 0x100000).
module sd_card_init_sequencer_core (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        cfg_wr_en,
    input  logic        cfg_index,
    input  logic [23:0] cfg_data,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_kind,
    input  logic [1:0]  s_reply_status,
    input  logic [31:0] s_response_word,

    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_cmd_valid,
    output logic [5:0]  m_cmd_index,
    output logic [31:0] m_cmd_arg,
    output logic        m_long_reply,
    output logic        m_finished,
    output logic [1:0]  m_outcome,
    output logic [1:0]  m_fail_code,
    output logic        m_high_capacity,
    output logic [15:0] m_card_addr
);
    import sdinit_pkg::*;

    cfg_t       cfg;
    seq_state_t state_reg;
    seq_state_t state_next;
    result_t    step_result;
    result_t    out_reg;

    logic        in_valid_reg;
    logic        in_valid_next;
    logic        in_kind_reg;
    logic [1:0]  in_status_reg;
    logic [31:0] in_word_reg;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic        advance;
    logic        accept;

    sdinit_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    sdinit_step u_step (
        .kind          (in_kind_reg),
        .reply_status  (in_status_reg),
        .response_word (in_word_reg),
        .state_cur     (state_reg),
        .cfg           (cfg),
        .state_next    (state_next),
        .result        (step_result)
    );

    // advance the input register into the result register when the latter frees up
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign accept  = s_valid && s_ready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (accept) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '{phase: PH_IDLE, attempts_left: 8'd0, host_hcs: 1'b0,
                               rel_addr: 16'h0000, card_hc: 1'b0};
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance) begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            in_kind_reg   <= s_kind;
            in_status_reg <= s_reply_status;
            in_word_reg   <= s_response_word;
        end
        if (advance) begin
            out_reg <= step_result;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_cmd_valid     = out_reg.cmd_valid;
    assign m_cmd_index     = out_reg.cmd_index;
    assign m_cmd_arg       = out_reg.cmd_arg;
    assign m_long_reply    = out_reg.long_reply;
    assign m_finished      = out_reg.finished;
    assign m_outcome       = out_reg.outcome;
    assign m_fail_code     = out_reg.fail_code;
    assign m_high_capacity = out_reg.high_capacity;
    assign m_card_addr     = out_reg.card_addr;

endmodule
